// ===== design/trmc_pkg.sv =====
// Shared types and constants for the throttle ramp motor controller.
package trmc_pkg;

   localparam int PEDAL_W   = 10;
   localparam int RATE_W    = 8;
   localparam int SPEED_W   = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;

   // Pedal rescale divider: 20-bit dividend, four quotient bits per cycle.
   localparam int QUO_W         = 20;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = QUO_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam int FULL_SCALE     = 1023;
   localparam int SPEED_NEAR_MAX = 254;
   localparam int SPEED_MAX      = 255;

   localparam logic [RATE_W-1:0]     RST_ACCEL_RATE       = 8'd10;
   localparam logic [RATE_W-1:0]     RST_DECEL_RATE       = 8'd10;
   localparam logic [RATE_W-1:0]     RST_BRAKE_RATE       = 8'd12;
   localparam logic [RATE_W-1:0]     RST_MAX_FORWARD_LOW  = 8'd125;
   localparam logic [RATE_W-1:0]     RST_MAX_FORWARD_HIGH = 8'd200;
   localparam logic [SPEED_W-1:0]    RST_MAX_REVERSE      = 9'h19C;  // -100
   localparam logic [PEDAL_W-1:0]    RST_PEDAL_DEAD_LEVEL = 10'd185;
   localparam logic [PEDAL_W-1:0]    RST_PEDAL_FULL_LEVEL = 10'd735;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL_RATE       = 3'd0,
      CSR_DECEL_RATE       = 3'd1,
      CSR_BRAKE_RATE       = 3'd2,
      CSR_MAX_FORWARD_LOW  = 3'd3,
      CSR_MAX_FORWARD_HIGH = 3'd4,
      CSR_MAX_REVERSE      = 3'd5,
      CSR_PEDAL_DEAD_LEVEL = 3'd6,
      CSR_PEDAL_FULL_LEVEL = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      GEAR_NEUTRAL  = 2'd0,
      GEAR_FWD_LOW  = 2'd1,
      GEAR_FWD_HIGH = 2'd2,
      GEAR_REVERSE  = 2'd3
   } gear_type;

   typedef enum logic [1:0] {
      DIR_STOP    = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } direction_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_QUOTIENT,
      ST_RAMP
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_en;
      logic quot_en;
      logic ramp_en;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== design/throttle_ramp_motor_controller_unit.sv =====
// Top level of the throttle ramp motor controller.
// Each accepted request passes through the pedal rescale divider (four quotient bits per
// cycle), then the multiply, divide by 1023 and ramp steps; rsp_valid is registered from the
// ramp step. A new request is taken only after the last one has finished the ramp step.
// A stalled response holds the ramp step, and with it the next request, until it is taken.
// Synchronous reset loads the default settings and clears the speed and response valid.
module throttle_ramp_motor_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [trmc_pkg::PEDAL_W-1:0]        req_pedal_sample,
   input  logic                                req_shift_contact_one,
   input  logic                                req_shift_contact_two,
   input  logic                                req_shift_contact_three,
   input  logic                                req_kill_active,
   input  logic                                req_settled,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [trmc_pkg::RATE_W-1:0]         rsp_forward_duty,
   output logic [trmc_pkg::RATE_W-1:0]         rsp_reverse_duty,
   output logic [1:0]                          rsp_direction,
   output logic [1:0]                          rsp_gear,
   output logic signed [trmc_pkg::SPEED_W-1:0] rsp_target_speed,
   output logic signed [trmc_pkg::SPEED_W-1:0] rsp_speed,
   input  logic                                csr_write_enable,
   input  logic [trmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trmc_pkg::CSR_DATA_W-1:0]     csr_data
);

   trmc_pkg::cmd_type    cmd;
   trmc_pkg::status_type status;

   trmc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trmc_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_pedal_sample        (req_pedal_sample),
      .req_shift_contact_one   (req_shift_contact_one),
      .req_shift_contact_two   (req_shift_contact_two),
      .req_shift_contact_three (req_shift_contact_three),
      .req_kill_active         (req_kill_active),
      .req_settled             (req_settled),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_forward_duty        (rsp_forward_duty),
      .rsp_reverse_duty        (rsp_reverse_duty),
      .rsp_direction           (rsp_direction),
      .rsp_gear                (rsp_gear),
      .rsp_target_speed        (rsp_target_speed),
      .rsp_speed               (rsp_speed)
   );

endmodule

// ===== design/trmc_controller.sv =====
// Sequencer that steps each request through divide, multiply, quotient and ramp.
module trmc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  trmc_pkg::status_type  status,
   output trmc_pkg::cmd_type     cmd
);

   trmc_pkg::state_type state_ff, state_in;
   logic [trmc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic div_last;

   assign div_last = (cnt_ff == trmc_pkg::DIV_CNT_W'(trmc_pkg::DIV_CYCLES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trmc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         trmc_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = trmc_pkg::ST_DIVIDE;
         end
         trmc_pkg::ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (div_last) state_in = trmc_pkg::ST_MULTIPLY;
         end
         trmc_pkg::ST_MULTIPLY: state_in = trmc_pkg::ST_QUOTIENT;
         trmc_pkg::ST_QUOTIENT: state_in = trmc_pkg::ST_RAMP;
         trmc_pkg::ST_RAMP: begin
            // The speed update waits until the response register can take it.
            if (status.out_free) state_in = trmc_pkg::ST_IDLE;
         end
         default: state_in = trmc_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         trmc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         trmc_pkg::ST_DIVIDE:   cmd.div_step = 1'b1;
         trmc_pkg::ST_MULTIPLY: cmd.mul_en   = 1'b1;
         trmc_pkg::ST_QUOTIENT: cmd.quot_en  = 1'b1;
         trmc_pkg::ST_RAMP:     cmd.ramp_en  = status.out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== design/trmc_datapath.sv =====
// Datapath: settings registers, pedal divider, gear scaling, speed ramp and response register.
module trmc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  trmc_pkg::cmd_type                  cmd,
   output trmc_pkg::status_type               status,
   input  logic                               csr_write_enable,
   input  logic [trmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [trmc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [trmc_pkg::PEDAL_W-1:0]       req_pedal_sample,
   input  logic                               req_shift_contact_one,
   input  logic                               req_shift_contact_two,
   input  logic                               req_shift_contact_three,
   input  logic                               req_kill_active,
   input  logic                               req_settled,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [trmc_pkg::RATE_W-1:0]        rsp_forward_duty,
   output logic [trmc_pkg::RATE_W-1:0]        rsp_reverse_duty,
   output logic [1:0]                         rsp_direction,
   output logic [1:0]                         rsp_gear,
   output logic signed [trmc_pkg::SPEED_W-1:0] rsp_target_speed,
   output logic signed [trmc_pkg::SPEED_W-1:0] rsp_speed
);

   localparam int PW = trmc_pkg::PEDAL_W;
   localparam int RW = trmc_pkg::RATE_W;
   localparam int SW = trmc_pkg::SPEED_W;
   localparam int QW = trmc_pkg::QUO_W;
   localparam int PRODW = PW + RW;
   localparam int WW = SW + 2;
   localparam logic signed [WW-1:0] SAT_HI   = WW'(trmc_pkg::SPEED_NEAR_MAX);
   localparam logic signed [WW-1:0] SAT_LO   = -WW'(trmc_pkg::SPEED_NEAR_MAX);
   localparam logic signed [WW-1:0] SPD_HI   = WW'(trmc_pkg::SPEED_MAX);
   localparam logic signed [WW-1:0] SPD_LO   = -WW'(trmc_pkg::SPEED_MAX);
   localparam logic signed [WW-1:0] ZERO_W   = '0;
   localparam logic [PW:0]          FULL_W   = (PW+1)'(trmc_pkg::FULL_SCALE);
   localparam logic [QW-1:0]        FULL_Q   = QW'(trmc_pkg::FULL_SCALE);
   localparam logic [SW-1:0]        REV_MIN  = {1'b1, {(SW-1){1'b0}}};

   // Settings registers
   logic [RW-1:0] accel_ff, decel_ff, brake_ff, fwd_low_ff, fwd_high_ff;
   logic signed [SW-1:0] max_rev_ff;
   logic [PW-1:0] dead_ff, full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff    <= trmc_pkg::RST_ACCEL_RATE;
         decel_ff    <= trmc_pkg::RST_DECEL_RATE;
         brake_ff    <= trmc_pkg::RST_BRAKE_RATE;
         fwd_low_ff  <= trmc_pkg::RST_MAX_FORWARD_LOW;
         fwd_high_ff <= trmc_pkg::RST_MAX_FORWARD_HIGH;
         max_rev_ff  <= trmc_pkg::RST_MAX_REVERSE;
         dead_ff     <= trmc_pkg::RST_PEDAL_DEAD_LEVEL;
         full_ff     <= trmc_pkg::RST_PEDAL_FULL_LEVEL;
      end else if (csr_write_enable) begin
         case (trmc_pkg::csr_index_type'(csr_index))
            trmc_pkg::CSR_ACCEL_RATE:       accel_ff    <= csr_data[RW-1:0];
            trmc_pkg::CSR_DECEL_RATE:       decel_ff    <= csr_data[RW-1:0];
            trmc_pkg::CSR_BRAKE_RATE:       brake_ff    <= csr_data[RW-1:0];
            trmc_pkg::CSR_MAX_FORWARD_LOW:  fwd_low_ff  <= csr_data[RW-1:0];
            trmc_pkg::CSR_MAX_FORWARD_HIGH: fwd_high_ff <= csr_data[RW-1:0];
            trmc_pkg::CSR_MAX_REVERSE:      max_rev_ff  <= csr_data[SW-1:0];
            trmc_pkg::CSR_PEDAL_DEAD_LEVEL: dead_ff     <= csr_data[PW-1:0];
            trmc_pkg::CSR_PEDAL_FULL_LEVEL: full_ff     <= csr_data[PW-1:0];
            default: ;
         endcase
      end
   end

   // Request capture
   logic [PW-1:0] pedal_diff, span;
   logic [QW-1:0] dividend;
   trmc_pkg::gear_type gear_dec;
   logic [RW-1:0] lim_mag;
   logic lim_neg;
   logic [SW-1:0] rev_neg;

   assign pedal_diff = req_pedal_sample - dead_ff;
   assign span       = full_ff - dead_ff;
   // (raw - dead) * 1023 as a shift and subtract
   assign dividend   = {pedal_diff, {PW{1'b0}}} - {{(QW-PW){1'b0}}, pedal_diff};
   assign rev_neg    = -max_rev_ff;

   always_comb begin
      case ({req_shift_contact_one, req_shift_contact_two, req_shift_contact_three})
         3'b101:  gear_dec = trmc_pkg::GEAR_REVERSE;
         3'b001:  gear_dec = trmc_pkg::GEAR_FWD_LOW;
         3'b010:  gear_dec = trmc_pkg::GEAR_FWD_HIGH;
         default: gear_dec = trmc_pkg::GEAR_NEUTRAL;
      endcase
   end

   always_comb begin
      lim_mag = '0;
      lim_neg = 1'b0;
      case (gear_dec)
         trmc_pkg::GEAR_FWD_LOW:  lim_mag = fwd_low_ff;
         trmc_pkg::GEAR_FWD_HIGH: lim_mag = fwd_high_ff;
         trmc_pkg::GEAR_REVERSE: begin
            if (max_rev_ff[SW-1]) begin
               lim_neg = 1'b1;
               // The most negative code is limited to the same magnitude as full speed.
               lim_mag = (max_rev_ff == REV_MIN) ? {RW{1'b1}} : rev_neg[RW-1:0];
            end else begin
               lim_mag = max_rev_ff[RW-1:0];
            end
         end
         default: lim_mag = '0;
      endcase
   end

   logic pedal_off_ff, full_span_ff, kill_ff, settled_ff, lim_neg_ff;
   logic [RW-1:0] lim_mag_ff;
   trmc_pkg::gear_type gear_ff;

   // Divider registers
   logic [QW-1:0] quo_ff, quo_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < trmc_pkg::DIV_STEP_BITS; i++) begin
         trial  = {rem_in, quo_in[QW-1]};
         quo_in = {quo_in[QW-2:0], 1'b0};
         if (trial >= {1'b0, span}) begin
            trial     = trial - {1'b0, span};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pedal_off_ff <= (req_pedal_sample <= dead_ff);
         full_span_ff <= (full_ff <= dead_ff);
         kill_ff      <= req_kill_active;
         settled_ff   <= req_settled;
         gear_ff      <= gear_dec;
         lim_mag_ff   <= lim_mag;
         lim_neg_ff   <= lim_neg;
         quo_ff       <= dividend;
         rem_ff       <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Gear scaling: once the pedal reaches full scale the clamp gives the limit itself.
   logic [PRODW-1:0] prod_ff;
   logic take_lim_ff, zero_tgt_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         zero_tgt_ff <= pedal_off_ff;
         take_lim_ff <= full_span_ff || (quo_ff >= FULL_Q);
         prod_ff     <= quo_ff[PW-1:0] * lim_mag_ff;
      end
   end

   // Divide the product by 1023: x = q*1024 + lo = q*1023 + (q + lo).
   logic [RW-1:0] q_hi, q_mag, tgt_mag;
   logic [PW:0]   q_rest;
   logic signed [SW-1:0] target_ff;

   assign q_hi   = prod_ff[PRODW-1:PW];
   assign q_rest = {1'b0, prod_ff[PW-1:0]} + {{(PW+1-RW){1'b0}}, q_hi};
   assign q_mag  = q_hi + RW'(q_rest >= FULL_W);

   always_comb begin
      if (zero_tgt_ff) tgt_mag = '0;
      else if (take_lim_ff) tgt_mag = lim_mag_ff;
      else tgt_mag = q_mag;
   end

   always_ff @(posedge clock) begin
      if (cmd.quot_en) begin
         target_ff <= lim_neg_ff ? -{1'b0, tgt_mag} : {1'b0, tgt_mag};
      end
   end

   // Speed ramp
   logic signed [SW-1:0] speed_ff;
   logic signed [WW-1:0] s_w, t_w, diff, acc_w, dec_w, brk_w, step_w, next_w, neg_w;

   always_ff @(posedge clock) begin
      if (reset) speed_ff <= '0;
      else if (cmd.ramp_en) speed_ff <= next_w[SW-1:0];
   end

   always_comb begin
      s_w    = WW'(speed_ff);
      t_w    = WW'(target_ff);
      acc_w  = {2'b00, 1'b0, accel_ff};
      dec_w  = {2'b00, 1'b0, decel_ff};
      brk_w  = {2'b00, 1'b0, brake_ff};
      diff   = t_w - s_w;
      step_w = s_w;
      if (settled_ff && !kill_ff) begin
         if (diff > ZERO_W) begin
            step_w = (diff <= acc_w) ? t_w : s_w + acc_w;
         end else if (diff < ZERO_W) begin
            step_w = (-diff <= dec_w) ? t_w : s_w - dec_w;
         end
      end else begin
         // Braking moves toward zero and never crosses it.
         if (s_w > ZERO_W) begin
            step_w = s_w - brk_w;
            if (step_w < ZERO_W) step_w = ZERO_W;
         end else if (s_w < ZERO_W) begin
            step_w = s_w + brk_w;
            if (step_w > ZERO_W) step_w = ZERO_W;
         end
      end
      if (step_w > SAT_HI) next_w = SPD_HI;
      else if (step_w < SAT_LO) next_w = SPD_LO;
      else next_w = step_w;
      neg_w = -next_w;
   end

   // Response register
   logic rsp_valid_ff;
   logic [RW-1:0] fwd_ff, rev_ff;
   trmc_pkg::direction_type dir_ff;
   trmc_pkg::gear_type rsp_gear_ff;
   logic signed [SW-1:0] rsp_target_ff, rsp_speed_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.ramp_en) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.ramp_en) begin
         fwd_ff        <= (next_w > ZERO_W) ? next_w[RW-1:0] : '0;
         rev_ff        <= (next_w < ZERO_W) ? neg_w[RW-1:0] : '0;
         if (next_w > ZERO_W) dir_ff <= trmc_pkg::DIR_FORWARD;
         else if (next_w < ZERO_W) dir_ff <= trmc_pkg::DIR_REVERSE;
         else dir_ff <= trmc_pkg::DIR_STOP;
         rsp_gear_ff   <= gear_ff;
         rsp_target_ff <= target_ff;
         rsp_speed_ff  <= next_w[SW-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_forward_duty = fwd_ff;
   assign rsp_reverse_duty = rev_ff;
   assign rsp_direction    = dir_ff;
   assign rsp_gear         = rsp_gear_ff;
   assign rsp_target_speed = rsp_target_ff;
   assign rsp_speed        = rsp_speed_ff;

endmodule
